// ===== hw/rtl/oaif_pkg.sv =====
package oaif_pkg;

  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int PosW      = $clog2(Depth);
  localparam int CntW      = $clog2(Depth + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;

  localparam logic [4:0] CapacityReset = 5'd10;

  typedef struct packed {
    logic                        ins;
    logic                        rem;
    logic [PosW-1:0]             pos;
    logic [CntW-1:0]             count;
    logic signed [DataWidth-1:0] value;
  } oaif_bcast_t;

endpackage

// ===== hw/rtl/oaif_cell.sv =====
module oaif_cell import oaif_pkg::*; (
  input  logic                        clk,
  input  logic [PosW-1:0]             idx,
  input  oaif_bcast_t                 bc,
  input  logic signed [DataWidth-1:0] left,
  input  logic signed [DataWidth-1:0] right,
  input  logic                        found_in,
  output logic signed [DataWidth-1:0] entry,
  output logic                        found_out,
  output logic                        first
);

  logic [CntW-1:0] idx_w;
  logic            active;
  logic            hit;

  assign idx_w     = CntW'(idx);
  assign active    = idx_w < bc.count;
  assign hit       = active && (entry == bc.value);
  assign found_out = found_in | hit;
  assign first     = hit & ~found_in;

  always_ff @(posedge clk) begin
    if (bc.ins) begin
      if (idx == bc.pos) begin
        entry <= bc.value;
      end else if ((idx > bc.pos) && (idx_w <= bc.count)) begin
        entry <= left;
      end
    end else if (bc.rem) begin
      if ((idx >= bc.pos) && ((idx_w + CntW'(1)) < bc.count)) begin
        entry <= right;
      end
    end
  end

endmodule

// ===== hw/rtl/ordered_array_insert_remove_find.sv =====
// Packed list of up to 16 signed 32-bit values, kept in a row of cells.
// Commands arrive on the input channel (in_valid / in_stall) as one beat:
//   cmd 0 insert value at position, cmd 1 remove entry at position,
//   cmd 2 find first position holding value; cmd 3 does nothing.
// Each command gives exactly one result beat on the output channel
// (out_valid / out_stall): status, found_position and count after it.
// The result is registered: an accepted beat shows its result in the cycle
// after acceptance. One command per cycle is sustained while no result is
// stalled, set by the single shift/compare step of the cell row; the result
// register lets the next command in while the previous result is being taken.
// While out_stall holds a pending result, in_stall is raised and the result
// is held unchanged until taken.
// cfg_write / cfg_wdata set the capacity (insert reports full at or above
// it, values above 16 act as 16); write only while idle.
// Reset empties the list, sets capacity to 10 and drops any pending result.
module ordered_array_insert_remove_find import oaif_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [4:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic signed [DataWidth-1:0] value,
  input  logic [PosW-1:0]             position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [PosW-1:0]             found_position,
  output logic [CntW-1:0]             count
);

  logic [4:0]                  capacity;
  logic [CntW-1:0]             eff_cap;
  logic [CntW-1:0]             entry_count;
  logic [CntW-1:0]             entry_count_next;
  logic                        acc;
  logic                        ins_ok;
  logic                        rem_ok;
  logic [2:0]                  status_next;
  logic [PosW-1:0]             fpos_next;
  oaif_bcast_t                 bc;
  logic signed [DataWidth-1:0] ent   [Depth];
  logic                        fchain[Depth+1];
  logic [Depth-1:0]            first;
  logic [PosW-1:0]             fpos_or;

  assign in_stall = out_valid & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign eff_cap  = (CntW'(capacity) > CntW'(Depth)) ? CntW'(Depth) : CntW'(capacity);

  assign ins_ok = acc && (cmd == CMD_INSERT) && (entry_count < eff_cap)
                  && (CntW'(position) <= entry_count);
  assign rem_ok = acc && (cmd == CMD_REMOVE) && (entry_count != '0)
                  && (CntW'(position) < entry_count);

  assign bc.ins   = ins_ok;
  assign bc.rem   = rem_ok;
  assign bc.pos   = position;
  assign bc.count = entry_count;
  assign bc.value = value;

  assign fchain[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    oaif_cell u_cell (
      .clk       (clk),
      .idx       (PosW'(i)),
      .bc        (bc),
      .left      ((i == 0) ? '0 : ent[(i == 0) ? 0 : i-1]),
      .right     ((i == Depth-1) ? '0 : ent[(i == Depth-1) ? i : i+1]),
      .found_in  (fchain[i]),
      .entry     (ent[i]),
      .found_out (fchain[i+1]),
      .first     (first[i])
    );
  end

  always_comb begin
    fpos_or = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first[i]) begin
        fpos_or = fpos_or | PosW'(i);
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    status_next      = ST_OK;
    fpos_next        = '0;
    case (cmd)
      CMD_INSERT: begin
        if (entry_count >= eff_cap) begin
          status_next = ST_FULL;
        end else if (CntW'(position) > entry_count) begin
          status_next = ST_BADPOS;
        end else begin
          entry_count_next = entry_count + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (entry_count == '0) begin
          status_next = ST_EMPTY;
        end else if (CntW'(position) >= entry_count) begin
          status_next = ST_BADPOS;
        end else begin
          entry_count_next = entry_count - CntW'(1);
        end
      end
      CMD_FIND: begin
        if (fchain[Depth]) begin
          fpos_next = fpos_or;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CapacityReset;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_wdata;
      end
      if (acc) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status         <= status_next;
      found_position <= fpos_next;
      count          <= entry_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(Depth))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> entry_count == $past(entry_count) + CntW'(1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    rem_ok |=> entry_count == $past(entry_count) - CntW'(1))
    else $error("remove did not shrink the list");

  a_single_first: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one first match");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    acc |=> count == entry_count)
    else $error("reported count differs from list count");

endmodule
